// ===== rtl/c3b_pkg.sv =====
// Shared types, widths and helpers for the 3x3 convolution block.
// No dependencies; used by every module in rtl/.
package c3b_pkg;

    localparam int PIX_W     = 8;
    localparam int COEF_W    = 6;
    localparam int COEF_FRAC = 4;
    localparam int VAL_W     = 18;
    localparam int ROW_W     = 12;
    localparam int COL_W     = 10;
    localparam int ROWS_CW   = 13;
    localparam int COLS_CW   = 11;
    localparam int MASK_W    = 54;
    localparam int PROD_W    = PIX_W + COEF_W + 1;
    localparam int PSUM_W    = PROD_W + 1;
    localparam int MAX_ROWS  = 4096;
    localparam int MAX_COLS  = 1024;
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW   = 4;
    localparam int FIFO_CW   = FIFO_AW + 1;
    localparam int MAX_RES   = 3;

    typedef enum logic [1:0] {
        CFG_ROWS = 2'd0,
        CFG_COLS = 2'd1,
        CFG_MASK = 2'd2
    } t_cfg_idx;

    // one window column, top row first
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } t_col;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic                    border;
        logic                    last;
        logic                    done;
    } t_result;

    // per-pixel position and flags carried down the pipeline
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             has_prev;
        logic             interior;
        logic             end_col;
        logic             last_row;
    } t_tag;

    function automatic logic signed [VAL_W-1:0] border_value(input logic [PIX_W-1:0] p);
        border_value = $signed({{(VAL_W-PIX_W-COEF_FRAC){1'b0}}, p, {COEF_FRAC{1'b0}}});
    endfunction

endpackage

// ===== rtl/conv3x3_border_passthrough.sv =====
// 3x3 convolution with border pass-through over a raster pixel stream.
// Path: a pixel's results are formed after stages s1, s2 and s3 and leave through the result queue.
// Throughput: one pixel per cycle while the result queue has room; the last row yields two results
// per pixel and row ends one extra, so the 16-entry result queue stalls input there, as does i_stall.
// Reset: synchronous, active low; size 2x2, zero mask, position and window
// cleared; line stores are not cleared (unwritten entries can be read but never reach a result).
module conv3x3_border_passthrough
    import c3b_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [PIX_W-1:0]         i_pixel,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [VAL_W-1:0]  o_value,
    output logic [ROW_W-1:0]         o_out_row,
    output logic [COL_W-1:0]         o_out_col,
    output logic                     o_is_border,
    output logic                     o_last_of_run,
    output logic                     o_frame_done,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_idx,
    input  logic [MASK_W-1:0]        i_cfg_data
);

    // configuration
    logic [ROWS_CW-1:0] r_rows;
    logic [COLS_CW-1:0] r_cols;
    logic [MASK_W-1:0]  r_mask;
    logic [ROWS_CW-1:0] w_rows;
    logic [COLS_CW-1:0] w_cols;

    // position of the next pixel
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   n_row;
    logic [COL_W-1:0]   n_col;

    logic               w_acc;
    logic               w_wrap;
    logic [ROWS_CW-1:0] w_row_inc;
    logic [ROW_W-1:0]   w_cur_r;
    logic [COL_W-1:0]   w_cur_c;
    t_tag               w_tag;

    // line stores
    logic [PIX_W-1:0]   r_upper  [MAX_COLS];
    logic [PIX_W-1:0]   r_middle [MAX_COLS];
    logic [PIX_W-1:0]   r_top_rd;
    logic [PIX_W-1:0]   r_mid_rd;

    // pipeline
    logic               r_s1_vld;
    t_tag               r_s1_tag;
    logic [PIX_W-1:0]   r_s1_pix;
    logic               r_s2_vld;
    t_tag               r_s2_tag;
    logic               r_s3_vld;
    t_tag               r_s3_tag;
    logic [PIX_W-1:0]   r_s3_w4;
    logic [PIX_W-1:0]   r_s3_mid;
    logic [PIX_W-1:0]   r_s3_bot;

    t_col                      w_cin  [3];
    t_col                      w_cout [3];
    logic [3*COEF_W-1:0]       w_coef [3];
    logic signed [PSUM_W-1:0]  w_psum [3];
    logic signed [VAL_W-1:0]   w_sum;

    t_result              w_ent [MAX_RES];
    logic [MAX_RES-1:0]   w_ent_vld;
    t_result              w_head;
    logic [FIFO_CW-1:0]   w_count;
    logic [1:0]           w_inflight;
    logic [FIFO_CW:0]     w_reserve;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= ROWS_CW'(2);
            r_cols <= COLS_CW'(2);
            r_mask <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROWS: r_rows <= i_cfg_data[ROWS_CW-1:0];
                CFG_COLS: r_cols <= i_cfg_data[COLS_CW-1:0];
                CFG_MASK: r_mask <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_rows = r_rows;
        if (r_rows < ROWS_CW'(2))        w_rows = ROWS_CW'(2);
        if (r_rows > ROWS_CW'(MAX_ROWS)) w_rows = ROWS_CW'(MAX_ROWS);
        w_cols = r_cols;
        if (r_cols < COLS_CW'(2))        w_cols = COLS_CW'(2);
        if (r_cols > COLS_CW'(MAX_COLS)) w_cols = COLS_CW'(MAX_COLS);
    end

    // ---------------- position ----------------
    assign w_reserve = (FIFO_CW+1)'(w_count) + (FIFO_CW+1)'({w_inflight, 1'b0})
                     + (FIFO_CW+1)'(w_inflight) + (FIFO_CW+1)'(MAX_RES);
    assign w_inflight = 2'(r_s1_vld) + 2'(r_s2_vld) + 2'(r_s3_vld);
    assign o_stall    = (w_reserve > (FIFO_CW+1)'(FIFO_DEPTH));
    assign w_acc      = i_valid && !o_stall;

    // a size change can leave the stored position outside the image
    always_comb begin
        w_wrap    = ({1'b0, r_col} >= w_cols);
        w_row_inc = {1'b0, r_row} + ROWS_CW'(w_wrap);
        w_cur_r   = (w_row_inc >= w_rows) ? '0 : w_row_inc[ROW_W-1:0];
        w_cur_c   = w_wrap ? '0 : r_col;

        w_tag.row      = w_cur_r;
        w_tag.col      = w_cur_c;
        w_tag.has_prev = (w_cur_r != '0) && (w_cur_c != '0);
        w_tag.interior = (w_cur_r >= ROW_W'(2)) && (w_cur_c >= COL_W'(2));
        w_tag.end_col  = ({1'b0, w_cur_c} + COLS_CW'(1)) == w_cols;
        w_tag.last_row = ({1'b0, w_cur_r} + ROWS_CW'(1)) == w_rows;

        if (w_tag.end_col) begin
            n_col = '0;
            n_row = w_tag.last_row ? '0 : w_cur_r + ROW_W'(1);
        end else begin
            n_col = w_cur_c + COL_W'(1);
            n_row = w_cur_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (w_acc) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // ---------------- line stores ----------------
    // read at transfer, write back in the next cycle at the same column
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_top_rd <= r_upper[w_cur_c];
        end
        if (r_s1_vld) begin
            r_upper[r_s1_tag.col] <= r_mid_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_mid_rd <= r_middle[w_cur_c];
        end
        if (r_s1_vld) begin
            r_middle[r_s1_tag.col] <= r_s1_pix;
        end
    end

    // ---------------- pipeline control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_acc;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_tag <= w_tag;
            r_s1_pix <= i_pixel;
        end
        r_s2_tag <= r_s1_tag;
        r_s3_tag <= r_s2_tag;
        r_s3_w4  <= w_cout[1].mid;
        r_s3_mid <= w_cout[2].mid;
        r_s3_bot <= w_cout[2].bot;
    end

    // ---------------- window cells ----------------
    // cell 2 takes the new column, older columns move toward cell 0
    assign w_cin[2] = '{top: r_top_rd, mid: r_mid_rd, bot: r_s1_pix};
    assign w_cin[1] = w_cout[2];
    assign w_cin[0] = w_cout[1];

    for (genvar j = 0; j < 3; j++) begin : g_cell
        assign w_coef[j] = {r_mask[(6+j)*COEF_W +: COEF_W],
                            r_mask[(3+j)*COEF_W +: COEF_W],
                            r_mask[j*COEF_W +: COEF_W]};

        c3b_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (r_s1_vld),
            .i_col   (w_cin[j]),
            .i_coef  (w_coef[j]),
            .o_col   (w_cout[j]),
            .o_psum  (w_psum[j])
        );
    end

    assign w_sum = VAL_W'(w_psum[0]) + VAL_W'(w_psum[1]) + VAL_W'(w_psum[2]);

    // ---------------- result forming ----------------
    always_comb begin
        w_ent[0].value  = r_s3_tag.interior ? w_sum : border_value(r_s3_w4);
        w_ent[0].row    = r_s3_tag.row - ROW_W'(1);
        w_ent[0].col    = r_s3_tag.col - COL_W'(1);
        w_ent[0].border = !r_s3_tag.interior;
        w_ent[0].done   = 1'b0;

        w_ent[1].value  = border_value(r_s3_mid);
        w_ent[1].row    = r_s3_tag.row - ROW_W'(1);
        w_ent[1].col    = r_s3_tag.col;
        w_ent[1].border = 1'b1;
        w_ent[1].done   = 1'b0;

        w_ent[2].value  = border_value(r_s3_bot);
        w_ent[2].row    = r_s3_tag.row;
        w_ent[2].col    = r_s3_tag.col;
        w_ent[2].border = 1'b1;
        w_ent[2].done   = r_s3_tag.end_col;

        w_ent_vld[0] = r_s3_vld && r_s3_tag.has_prev;
        w_ent_vld[1] = r_s3_vld && r_s3_tag.has_prev && r_s3_tag.end_col;
        w_ent_vld[2] = r_s3_vld && r_s3_tag.last_row;

        w_ent[2].last = 1'b1;
        w_ent[1].last = !w_ent_vld[2];
        w_ent[0].last = !w_ent_vld[2] && !w_ent_vld[1];
    end

    c3b_out_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ent     (w_ent),
        .i_ent_vld (w_ent_vld),
        .i_stall   (i_stall),
        .o_valid   (o_valid),
        .o_head    (w_head),
        .o_count   (w_count)
    );

    assign o_value       = w_head.value;
    assign o_out_row     = w_head.row;
    assign o_out_col     = w_head.col;
    assign o_is_border   = w_head.border;
    assign o_last_of_run = w_head.last;
    assign o_frame_done  = w_head.done;

endmodule

// ===== rtl/c3b_cell.sv =====
// One window column cell: holds a pixel column, hands it to its older
// neighbor on each shift, and registers its share of the weighted sum.
// Depends on c3b_pkg.
module c3b_cell
    import c3b_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_shift,
    input  t_col                      i_col,
    input  logic [3*COEF_W-1:0]       i_coef,
    output t_col                      o_col,
    output logic signed [PSUM_W-1:0]  o_psum
);

    t_col                     r_col;
    logic signed [PSUM_W-1:0] r_psum;
    logic signed [PROD_W-1:0] w_p_top;
    logic signed [PROD_W-1:0] w_p_mid;
    logic signed [PROD_W-1:0] w_p_bot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign w_p_top = $signed({1'b0, r_col.top}) * $signed(i_coef[0*COEF_W +: COEF_W]);
    assign w_p_mid = $signed({1'b0, r_col.mid}) * $signed(i_coef[1*COEF_W +: COEF_W]);
    assign w_p_bot = $signed({1'b0, r_col.bot}) * $signed(i_coef[2*COEF_W +: COEF_W]);

    always_ff @(posedge i_clk) begin
        r_psum <= PSUM_W'(w_p_top) + PSUM_W'(w_p_mid) + PSUM_W'(w_p_bot);
    end

    assign o_col  = r_col;
    assign o_psum = r_psum;

endmodule

// ===== rtl/c3b_out_fifo.sv =====
// Result queue: takes up to three results per cycle in order, hands out one unless i_stall is high.
// Depends on c3b_pkg.
module c3b_out_fifo
    import c3b_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_result            i_ent [MAX_RES],
    input  logic [MAX_RES-1:0] i_ent_vld,
    input  logic               i_stall,
    output logic               o_valid,
    output t_result            o_head,
    output logic [FIFO_CW-1:0] o_count
);

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wp;
    logic [FIFO_AW-1:0]   r_rp;
    logic [FIFO_CW-1:0]   r_count;
    logic [FIFO_AW-1:0]   w_addr [MAX_RES];
    logic [1:0]           w_npush;
    logic                 w_pop;

    // entries are packed toward the write pointer in arrival order
    assign w_addr[0] = r_wp;
    assign w_addr[1] = r_wp + FIFO_AW'(i_ent_vld[0]);
    assign w_addr[2] = r_wp + FIFO_AW'(i_ent_vld[0]) + FIFO_AW'(i_ent_vld[1]);
    assign w_npush   = 2'(i_ent_vld[0]) + 2'(i_ent_vld[1]) + 2'(i_ent_vld[2]);
    assign w_pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (i_ent_vld[k]) begin
                r_mem[w_addr[k]] <= i_ent[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + FIFO_AW'(w_npush);
            r_rp    <= r_rp + FIFO_AW'(w_pop);
            r_count <= r_count + FIFO_CW'(w_npush) - FIFO_CW'(w_pop);
        end
    end

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rp];
    assign o_count = r_count;

endmodule
